// ----- src/sbvs_pkg.sv -----
// Package for the segment buffer victim select unit.
// Holds the command codes, state machine type and shared widths; no dependencies.
package sbvs_pkg;

  localparam int FileW = 16;
  localparam int SegW  = 20;
  localparam int TickW = 32;
  localparam int CapW  = 5;
  localparam int EntW  = FileW + SegW + TickW;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_SHIFT,
    ST_APPEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FileW-1:0] file_id;
    logic [SegW-1:0]  seg_id;
    logic [TickW-1:0] last_use;
  } entry_t;

endpackage

// ----- src/sbvs_if.sv -----
// Valid/ready channel interfaces for the segment buffer victim select unit.
// Depends on sbvs_pkg for field widths.
interface sbvs_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [sbvs_pkg::FileW-1:0] file_id;
  logic [sbvs_pkg::SegW-1:0]  seg_id;
  modport source (output valid, command, file_id, seg_id, input ready);
  modport sink   (input valid, command, file_id, seg_id, output ready);
endinterface

interface sbvs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic                      evicted;
  logic [sbvs_pkg::FileW-1:0] evicted_file_id;
  logic [sbvs_pkg::SegW-1:0]  evicted_seg_id;
  modport source (output valid, found, evicted, evicted_file_id, evicted_seg_id, input ready);
  modport sink   (input valid, found, evicted, evicted_file_id, evicted_seg_id, output ready);
endinterface

// ----- src/sbvs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/segment_buffer_victim_select_unit.sv -----
// Segment buffer victim select unit: top level with sequencer and entry RAM.
// Read and find walk the filled entries; a no-op or empty read returns a result; a write
// appends, or when full scans, compacts and appends; two 32x20 multiplies per compare step.
// Throughput: one item at a time; the next item is taken the cycle after the result is.
// Reset (rst, synchronous) empties the buffer, zeroes the tick and sets capacity to 16.
// The RAM is not cleared; only the first fill entries are ever read.
module segment_buffer_victim_select_unit #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sbvs_pkg::CapW-1:0]   cfg_wdata,
  sbvs_req_if.sink                    req,
  sbvs_rsp_if.source                  rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sbvs_pkg::state_t state, state_next;

  logic [sbvs_pkg::CapW-1:0]  capacity;
  logic [CW-1:0]              fill_count;
  logic [sbvs_pkg::TickW-1:0] tick;
  logic [1:0]                 cmd;
  logic [sbvs_pkg::FileW-1:0] key_file;
  logic [sbvs_pkg::SegW-1:0]  key_seg;
  logic [CW-1:0]              idx;
  logic                       rd_pend;
  logic                       hit;
  logic [AW-1:0]              hit_idx;
  logic                       have;
  logic                       best_neg;
  logic [AW-1:0]              best;
  logic [sbvs_pkg::SegW-1:0]  best_mag;
  logic [sbvs_pkg::TickW-1:0] best_age;
  logic [sbvs_pkg::SegW-1:0]  best_den;
  logic [sbvs_pkg::TickW-1:0] c_age;
  logic [sbvs_pkg::SegW-1:0]  c_den;
  logic [AW-1:0]              c_idx;
  logic [51:0]                prod_a;
  logic [51:0]                prod_b;
  logic                       pos_win;
  logic [AW-1:0]              victim_sel;
  logic                       out_valid;
  logic                       out_found;
  logic                       out_evicted;
  logic [sbvs_pkg::FileW-1:0] out_file;
  logic [sbvs_pkg::SegW-1:0]  out_seg;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  sbvs_pkg::entry_t           ram_wdata;
  logic [AW-1:0]              ram_raddr;
  sbvs_pkg::entry_t           ram_rdata;

  logic [CW-1:0]              eff_cap;
  logic                       scan_last;

  sbvs_ram #(.WIDTH(sbvs_pkg::EntW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective capacity clamped to 1..DEPTH.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(capacity) > DEPTH) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  // The read issued last cycle returns the final entry of the walk.
  assign scan_last = rd_pend && (idx == fill_count);

  // Cross products of the pending candidate and the best positive weight.
  assign prod_a = 52'(c_age) * 52'(best_den);
  assign prod_b = 52'(best_age) * 52'(c_den);

  // The pending positive candidate beats the current best.
  assign pos_win = (c_den != '0) && (!have || (!best_neg && prod_a < prod_b));
  assign victim_sel = pos_win ? c_idx : (have ? best : '0);

  assign req.ready = (state == sbvs_pkg::ST_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.found = out_found;
  assign rsp.evicted = out_evicted;
  assign rsp.evicted_file_id = out_file;
  assign rsp.evicted_seg_id = out_seg;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbvs_pkg::ST_IDLE: begin
        if (req.valid && req.ready) begin
          if (req.command == sbvs_pkg::CMD_NOP) begin
            state_next = sbvs_pkg::ST_DONE;
          end else if (req.command == sbvs_pkg::CMD_WRITE && fill_count < eff_cap) begin
            state_next = sbvs_pkg::ST_APPEND;
          end else if (fill_count == '0) begin
            state_next = sbvs_pkg::ST_DONE;
          end else begin
            state_next = sbvs_pkg::ST_SCAN;
          end
        end
      end
      sbvs_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = (cmd == sbvs_pkg::CMD_WRITE) ? sbvs_pkg::ST_CMP : sbvs_pkg::ST_DONE;
        end
      end
      sbvs_pkg::ST_CMP: begin
        state_next = sbvs_pkg::ST_SHIFT;
      end
      sbvs_pkg::ST_SHIFT: begin
        if (idx >= fill_count) begin
          state_next = sbvs_pkg::ST_APPEND;
        end
      end
      sbvs_pkg::ST_APPEND: begin
        state_next = sbvs_pkg::ST_DONE;
      end
      sbvs_pkg::ST_DONE: begin
        state_next = sbvs_pkg::ST_IDLE;
      end
      default: begin
        state_next = sbvs_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM port: reads walk idx; shift copies entry idx-1 to idx-2; append and read hit write.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    case (state)
      sbvs_pkg::ST_IDLE: begin
        ram_raddr = '0;
      end
      sbvs_pkg::ST_CMP: begin
        ram_raddr = victim_sel;
      end
      sbvs_pkg::ST_SHIFT: begin
        if (rd_pend) begin
          ram_we = 1'b1;
          ram_waddr = AW'(idx - CW'(2));
        end
      end
      sbvs_pkg::ST_APPEND: begin
        ram_we = 1'b1;
        ram_waddr = fill_count[AW-1:0];
        ram_wdata = '{file_id: key_file, seg_id: key_seg, last_use: tick};
      end
      sbvs_pkg::ST_DONE: begin
        if (cmd == sbvs_pkg::CMD_READ && hit) begin
          ram_we = 1'b1;
          ram_waddr = hit_idx;
          ram_wdata = '{file_id: key_file, seg_id: key_seg, last_use: tick};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbvs_pkg::ST_IDLE;
      capacity <= sbvs_pkg::CapW'(16);
      fill_count <= '0;
      tick <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      hit <= 1'b0;
      have <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        sbvs_pkg::ST_IDLE: begin
          if (req.valid && req.ready) begin
            cmd <= req.command;
            key_file <= req.file_id;
            key_seg <= req.seg_id;
            idx <= CW'(1);
            rd_pend <= 1'b1;
            hit <= 1'b0;
            have <= 1'b0;
            best <= '0;
            best_neg <= 1'b0;
            c_den <= '0;
            c_age <= '0;
            best_den <= '0;
            best_age <= '0;
            out_found <= 1'b0;
            out_evicted <= 1'b0;
            out_file <= '0;
            out_seg <= '0;
          end
        end
        sbvs_pkg::ST_SCAN, sbvs_pkg::ST_CMP: begin
          // Resolve the positive candidate from the previous step.
          if (pos_win) begin
            have <= 1'b1;
            best_neg <= 1'b0;
            best <= c_idx;
            best_age <= c_age;
            best_den <= c_den;
          end
          c_den <= '0;
          if (state == sbvs_pkg::ST_SCAN) begin
            // Search and victim steps on the entry just read.
            if (!hit && ram_rdata.file_id == key_file && ram_rdata.seg_id == key_seg) begin
              hit <= 1'b1;
              hit_idx <= AW'(idx - CW'(1));
            end
            if (ram_rdata.seg_id < key_seg) begin
              if (!have || !best_neg || (key_seg - ram_rdata.seg_id) > best_mag ||
                  (c_den != '0 && !have)) begin
                if (!(have && best_neg && (key_seg - ram_rdata.seg_id) <= best_mag)) begin
                  have <= 1'b1;
                  best_neg <= 1'b1;
                  best <= AW'(idx - CW'(1));
                  best_mag <= key_seg - ram_rdata.seg_id;
                end
              end
            end else if (ram_rdata.seg_id > key_seg && !(have && best_neg)) begin
              c_den <= ram_rdata.seg_id - key_seg;
              c_age <= tick - ram_rdata.last_use;
              c_idx <= AW'(idx - CW'(1));
            end
            if (scan_last) begin
              rd_pend <= 1'b0;
            end else begin
              idx <= idx + CW'(1);
            end
          end else begin
            // Victim known after this step: begin the compaction walk.
            idx <= CW'(victim_sel) + CW'(1);
            rd_pend <= 1'b0;
          end
        end
        sbvs_pkg::ST_SHIFT: begin
          if (!rd_pend) begin
            // First cycle: the read of the victim returns now.
            out_evicted <= 1'b1;
            out_file <= ram_rdata.file_id;
            out_seg <= ram_rdata.seg_id;
          end
          if (idx >= fill_count) begin
            fill_count <= fill_count - CW'(1);
            rd_pend <= 1'b0;
          end else begin
            idx <= idx + CW'(1);
            rd_pend <= 1'b1;
          end
        end
        sbvs_pkg::ST_APPEND: begin
          fill_count <= fill_count + CW'(1);
          tick <= tick + 1'b1;
        end
        sbvs_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          if (cmd != sbvs_pkg::CMD_WRITE) begin
            out_found <= hit;
          end
          if (cmd == sbvs_pkg::CMD_READ && hit) begin
            tick <= tick + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ----- src/sbvs_checker.sv -----
// Port-level checker for the segment buffer victim select unit, with its bind.
// Depends on sbvs_pkg and the top-level port names.
module sbvs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_found,
  input logic                        rsp_evicted,
  input logic [sbvs_pkg::FileW-1:0]  rsp_file,
  input logic [sbvs_pkg::SegW-1:0]   rsp_seg
);
  // A result never carries both a hit and an eviction.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_found && rsp_evicted)) else $error("found and evicted together");

  // Without an eviction the victim fields are zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_evicted) |-> (rsp_file == '0 && rsp_seg == '0))
    else $error("victim fields not zero");

  // No new item is taken while a result is still pending.
  a_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("input accepted with result pending");

  // A result stalled by the sink stays valid and holds its found and evicted flags.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) && $stable(rsp_evicted)))
    else $error("stalled result changed");
endmodule

bind segment_buffer_victim_select_unit sbvs_checker u_sbvs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_found   (rsp.found),
  .rsp_evicted (rsp.evicted),
  .rsp_file    (rsp.evicted_file_id),
  .rsp_seg     (rsp.evicted_seg_id)
);

// ----- bench/sbvs_tb_if.sv -----
// Testbench package with the expected-result type of the unit.
// The channel interfaces come from src/sbvs_if.sv; depends on sbvs_pkg.
package sbvs_tb_pkg;

  // One expected result of the unit.
  typedef struct packed {
    logic                       found;
    logic                       evicted;
    logic [sbvs_pkg::FileW-1:0] evicted_file_id;
    logic [sbvs_pkg::SegW-1:0]  evicted_seg_id;
  } outcome_t;
endpackage

// ----- bench/testbench.sv -----
// Self-checking testbench for segment_buffer_victim_select_unit.
// Drives read, write, find and no-op items with random stalls and checks every result
// against an in-bench model of the buffer; depends on sbvs_pkg, sbvs_if and sbvs_tb_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int StallLimit = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sbvs_pkg::CapW-1:0] cfg_wdata;

  sbvs_req_if req ();
  sbvs_rsp_if rsp ();

  segment_buffer_victim_select_unit #(.DEPTH(Depth)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  // Model state of the buffer.
  logic [sbvs_pkg::FileW-1:0] buf_file [Depth];
  logic [sbvs_pkg::SegW-1:0]  buf_seg [Depth];
  logic [sbvs_pkg::TickW-1:0] buf_use [Depth];
  int unsigned                buf_fill;
  logic [sbvs_pkg::TickW-1:0] buf_tick;
  logic [sbvs_pkg::CapW-1:0]  buf_capacity;

  sbvs_tb_pkg::outcome_t pending_outcomes[$];
  int  error_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_capacity();
    int c;
    c = buf_capacity;
    if (c < 1) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  // Index of the entry to evict for new segment s.
  function automatic int choose_victim(logic [sbvs_pkg::SegW-1:0] s);
    int best;
    bit have;
    bit best_neg;
    logic [sbvs_pkg::SegW-1:0] best_mag;
    logic [63:0] best_age;
    logic [63:0] best_den;
    logic [63:0] age;
    logic [63:0] den;
    bit less;
    best = 0; have = 0; best_neg = 0; best_mag = '0; best_age = '0; best_den = 64'd1;
    for (int i = 0; i < buf_fill; i++) begin
      if (buf_seg[i] == s) continue;
      if (buf_seg[i] < s) begin
        less = !have || !best_neg || ((s - buf_seg[i]) > best_mag);
        if (less) begin
          have = 1; best = i; best_neg = 1; best_mag = s - buf_seg[i];
        end
      end else begin
        age = {32'd0, buf_tick - buf_use[i]};
        den = {44'd0, buf_seg[i] - s};
        if (!have) less = 1;
        else if (best_neg) less = 0;
        else less = (age * best_den) < (best_age * den);
        if (less) begin
          have = 1; best = i; best_neg = 0; best_age = age; best_den = den;
        end
      end
    end
    return best;
  endfunction

  // Apply one item to the model and return its expected result.
  function automatic sbvs_tb_pkg::outcome_t buffer_access(sbvs_pkg::cmd_t cmd,
                                                          logic [sbvs_pkg::FileW-1:0] f,
                                                          logic [sbvs_pkg::SegW-1:0] s);
    sbvs_tb_pkg::outcome_t o;
    int hit;
    int v;
    o = '0;
    hit = -1;
    if (cmd == sbvs_pkg::CMD_READ || cmd == sbvs_pkg::CMD_FIND) begin
      for (int i = 0; i < buf_fill; i++) begin
        if (hit < 0 && buf_file[i] == f && buf_seg[i] == s) hit = i;
      end
      if (hit >= 0) begin
        o.found = 1'b1;
        if (cmd == sbvs_pkg::CMD_READ) begin
          buf_use[hit] = buf_tick;
          buf_tick = buf_tick + 1;
        end
      end
    end else if (cmd == sbvs_pkg::CMD_WRITE) begin
      if (buf_fill >= clamp_capacity() && buf_fill > 0) begin
        v = choose_victim(s);
        o.evicted = 1'b1;
        o.evicted_file_id = buf_file[v];
        o.evicted_seg_id = buf_seg[v];
        for (int i = v; i < buf_fill - 1; i++) begin
          buf_file[i] = buf_file[i+1];
          buf_seg[i] = buf_seg[i+1];
          buf_use[i] = buf_use[i+1];
        end
        buf_fill--;
      end
      if (buf_fill < Depth) begin
        buf_file[buf_fill] = f;
        buf_seg[buf_fill] = s;
        buf_use[buf_fill] = buf_tick;
        buf_fill++;
        buf_tick = buf_tick + 1;
      end
    end
    return o;
  endfunction

  // Receiver ready with random idling and optional long hold.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sbvs_tb_pkg::outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no expectation waiting");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0h actual %0h", want.found, rsp.found);
          error_count++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0h actual %0h", want.evicted, rsp.evicted);
          error_count++;
        end
        if (rsp.evicted_file_id !== want.evicted_file_id) begin
          $error("evicted_file_id: expected %0h actual %0h",
                 want.evicted_file_id, rsp.evicted_file_id);
          error_count++;
        end
        if (rsp.evicted_seg_id !== want.evicted_seg_id) begin
          $error("evicted_seg_id: expected %0h actual %0h",
                 want.evicted_seg_id, rsp.evicted_seg_id);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("segment_buffer_victim_select_unit test failed");
      $finish;
    end
  end

  // Send one item, with random idle cycles before it; valid stays high after acceptance
  // until the next item or an idle cycle replaces it.
  task automatic send_item(sbvs_pkg::cmd_t cmd, logic [sbvs_pkg::FileW-1:0] f,
                           logic [sbvs_pkg::SegW-1:0] s);
    sbvs_tb_pkg::outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.file_id <= f;
    req.seg_id <= s;
    o = buffer_access(cmd, f, s);
    pending_outcomes = {pending_outcomes, o};
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2 * Depth + 10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [sbvs_pkg::CapW-1:0] c);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_capacity = c;
  endtask

  // Directed: field extremes, all commands, ties, equal segments, clamping.
  task automatic test_directed();
    send_item(sbvs_pkg::CMD_FIND, 16'h0000, 20'h00000);
    send_item(sbvs_pkg::CMD_READ, 16'hFFFF, 20'hFFFFF);
    send_item(sbvs_pkg::CMD_WRITE, 16'hFFFF, 20'hFFFFF);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0000, 20'h00000);
    send_item(sbvs_pkg::CMD_READ, 16'hFFFF, 20'hFFFFF);
    send_item(sbvs_pkg::CMD_FIND, 16'h0000, 20'h00000);
    send_item(sbvs_pkg::CMD_NOP, 16'hFFFF, 20'hFFFFF);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0000, 20'h00000);
    write_capacity(5'd0);
    send_item(sbvs_pkg::CMD_WRITE, 16'h1234, 20'h00000);
    send_item(sbvs_pkg::CMD_WRITE, 16'h1235, 20'h00010);
    write_capacity(5'd3);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0001, 20'h00010);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0002, 20'h00010);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0003, 20'h00010);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0004, 20'h00020);
    send_item(sbvs_pkg::CMD_WRITE, 16'h0005, 20'h00005);
    write_capacity(5'd31);
    for (int i = 0; i < 8; i++) send_item(sbvs_pkg::CMD_WRITE, 16'(i), 20'(100 + i));
  endtask

  // Random items; mostly addresses drawn from a small pool so reads hit.
  task automatic test_random(int count, logic [sbvs_pkg::CapW-1:0] cap);
    logic [sbvs_pkg::FileW-1:0] f;
    logic [sbvs_pkg::SegW-1:0] s;
    sbvs_pkg::cmd_t cmd;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      cmd = sbvs_pkg::cmd_t'($urandom_range(3));
      if ($urandom_range(9) < 8) begin
        f = 16'($urandom_range(3));
        s = 20'($urandom_range(40));
      end else begin
        f = 16'($urandom);
        s = 20'($urandom);
      end
      send_item(cmd, f, s);
    end
  endtask

  // Long receiver hold while items keep coming, then a drained pause.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      for (int n = 0; n < 6; n++) begin
        send_item(sbvs_pkg::CMD_WRITE, 16'(n), 20'($urandom_range(50)));
      end
    join
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.command = 2'd0;
    req.file_id = '0;
    req.seg_id = '0;
    recv_hold = 0;
    error_count = 0;
    buf_fill = 0;
    buf_tick = '0;
    buf_capacity = 5'd16;
    send_idle_pct = 31;
    recv_idle_pct = 77;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(300, 5'd4);
    test_random(300, 5'd16);
    send_idle_pct = 77;
    recv_idle_pct = 31;
    test_random(300, 5'd1);
    test_random(300, 5'd8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350, 5'd20);
    test_random(350, 5'd2);
    wait_drained();
    if (error_count == 0) $display("segment_buffer_victim_select_unit test passed");
    else $display("segment_buffer_victim_select_unit test failed");
    $finish;
  end
endmodule

// ----- files.f -----
src/sbvs_pkg.sv
src/sbvs_if.sv
src/sbvs_ram.sv
src/segment_buffer_victim_select_unit.sv
src/sbvs_checker.sv
bench/sbvs_tb_if.sv
bench/testbench.sv
